[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property that must hold at every clock edge.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: property failed");

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

[design/clcr_pkg.sv]
// ----------------------------------------------------------------------------
// clcr_pkg
// Constants, message tables and types of the control link client responder.
// ----------------------------------------------------------------------------
package clcr_pkg;

  localparam logic [7:0]  KindRegister  = 8'h0f;
  localparam logic [7:0]  KindResult    = 8'h02;
  localparam logic [7:0]  MatchLen      = 8'd4;
  localparam logic [15:0] PeriodReset   = 16'd5;

  localparam logic [4:0]  ReplyLen      = 5'd14;
  localparam logic [4:0]  AckLen        = 5'd8;
  localparam logic [4:0]  BeatLen       = 5'd5;

  // Which message sequence an item sends
  typedef enum logic [1:0] {
    SelBeat     = 2'd0,
    SelReply    = 2'd1,
    SelAck      = 2'd2,
    SelReplyAck = 2'd3
  } msg_sel_e;

  typedef struct packed {
    logic     valid;
    msg_sel_e sel;
  } msg_desc_t;

  function automatic logic [7:0] match_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd3:    b = 8'h1f;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:    b = 8'h01;
      4'd2:    b = 8'h0b;
      4'd8:    b = 8'h03;
      4'd9:    b = 8'h40;
      4'd10:   b = 8'hff;
      4'd11:   b = 8'hff;
      4'd12:   b = 8'hf1;
      4'd13:   b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ack_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = 8'h05;
      3'd2:    b = 8'h05;
      3'd5:    b = 8'h02;
      3'd6:    b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] beat_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = 8'h0d;
      3'd2:    b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] msg_len(input msg_sel_e sel);
    logic [4:0] n;
    case (sel)
      SelReply:    n = ReplyLen;
      SelAck:      n = AckLen;
      SelReplyAck: n = ReplyLen + AckLen;
      default:     n = BeatLen;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] msg_byte(input msg_sel_e sel, input logic [4:0] idx);
    logic [4:0] ack_idx;
    logic [7:0] b;
    ack_idx = idx - ReplyLen;
    case (sel)
      SelReply:    b = reply_byte(idx[3:0]);
      SelAck:      b = ack_byte(idx[2:0]);
      SelReplyAck: b = (idx < ReplyLen) ? reply_byte(idx[3:0]) : ack_byte(ack_idx[2:0]);
      default:     b = beat_byte(idx[2:0]);
    endcase
    return b;
  endfunction

endpackage

[design/control_link_client_responder.sv]
// When idle, the first byte of a reply is offered the cycle after the item that causes it.
// Throughput: one input item per cycle until a reply sequence waits behind the one sending;
// input then stalls till that one ends. Sequences run 5, 8, 14 or 22 bytes, one byte per beat.
// One byte a cycle while out_ready_i is high: the output sequencer sets the rate in reply bursts.
// Reset (rst_ni low, asynchronous): parser to type byte, tick count 0, queue empty,
// heartbeat period back to 5.
// ----------------------------------------------------------------------------
// control_link_client_responder
// Frame parser with fixed reply, acknowledgment and heartbeat message output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module control_link_client_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o
);
  import clcr_pkg::*;

  typedef enum logic [3:0] {
    PhType    = 4'b0001,
    PhLenHi   = 4'b0010,
    PhLenLo   = 4'b0100,
    PhPayload = 4'b1000
  } parse_phase_e;

  parse_phase_e phase_q, phase_d;
  logic [7:0]   kind_q, kind_d;
  logic [7:0]   len_q, len_d;
  logic [7:0]   left_q, left_d;
  logic         match_q, match_d;
  logic [15:0]  tick_q, tick_d;
  logic [15:0]  period_q;

  msg_desc_t    new_desc;
  msg_desc_t    pend_q, pend_d;
  logic         busy_q, busy_d;
  msg_sel_e     sel_q, sel_d;
  logic [4:0]   idx_q, idx_d;

  logic         acc;
  logic         finish;
  logic         send_ack;
  logic         is_reg;
  logic [7:0]   pos;
  logic [7:0]   left_dec;
  logic [15:0]  tick_inc;
  logic         out_last;
  logic         emit_done;
  logic         emit_free;

  // ---- parser ----
  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    len_d    = len_q;
    left_d   = left_q;
    match_d  = match_q;
    tick_d   = tick_q;
    new_desc = '{valid: 1'b0, sel: SelBeat};
    finish   = 1'b0;
    pos      = len_q - left_q;
    left_dec = left_q - 8'd1;
    tick_inc = tick_q + 16'd1;
    if (req_type_i) begin
      if (tick_inc >= period_q) begin
        tick_d   = '0;
        new_desc = '{valid: 1'b1, sel: SelBeat};
      end else begin
        tick_d = tick_inc;
      end
    end else begin
      case (phase_q)
        PhType: begin
          kind_d  = rx_byte_i;
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_d   = rx_byte_i;
          left_d  = rx_byte_i;
          match_d = 1'b1;
          if (rx_byte_i == 8'd0) begin
            finish  = 1'b1;
            phase_d = PhType;
          end else begin
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          if (pos < MatchLen && rx_byte_i != match_byte(pos[1:0])) begin
            match_d = 1'b0;
          end
          left_d = left_dec;
          if (left_dec == 8'd0) begin
            finish  = 1'b1;
            phase_d = PhType;
          end
        end
        default: begin
          phase_d = PhType;
        end
      endcase
    end
    is_reg   = (kind_q == KindRegister);
    send_ack = (is_reg || kind_q == KindResult) && len_d == MatchLen && match_d;
    if (finish) begin
      if (is_reg && send_ack) begin
        new_desc = '{valid: 1'b1, sel: SelReplyAck};
      end else if (is_reg) begin
        new_desc = '{valid: 1'b1, sel: SelReply};
      end else if (send_ack) begin
        new_desc = '{valid: 1'b1, sel: SelAck};
      end
    end
  end

  // ---- output sequencer and one-deep queue ----
  assign out_last   = (idx_q == msg_len(sel_q) - 5'd1);
  assign emit_done  = busy_q && out_ready_i && out_last;
  assign emit_free  = !busy_q || emit_done;
  assign in_ready_o = !pend_q.valid || emit_free;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    sel_d  = sel_q;
    idx_d  = idx_q;
    pend_d = pend_q;
    if (emit_free) begin
      idx_d = '0;
      if (pend_q.valid) begin
        busy_d = 1'b1;
        sel_d  = pend_q.sel;
        pend_d = (acc && new_desc.valid) ? new_desc : '{valid: 1'b0, sel: SelBeat};
      end else if (acc && new_desc.valid) begin
        busy_d = 1'b1;
        sel_d  = new_desc.sel;
      end else begin
        busy_d = 1'b0;
      end
    end else begin
      // advance within the current message, park a new one behind it
      if (out_ready_i) begin
        idx_d = idx_q + 5'd1;
      end
      if (acc && new_desc.valid) begin
        pend_d = new_desc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhType;
      kind_q   <= '0;
      len_q    <= '0;
      left_q   <= '0;
      match_q  <= 1'b1;
      tick_q   <= '0;
      period_q <= PeriodReset;
      busy_q   <= 1'b0;
      sel_q    <= SelBeat;
      idx_q    <= '0;
      pend_q   <= '{valid: 1'b0, sel: SelBeat};
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (acc) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        len_q   <= len_d;
        left_q  <= left_d;
        match_q <= match_d;
        tick_q  <= tick_d;
      end
      busy_q <= busy_d;
      sel_q  <= sel_d;
      idx_q  <= idx_d;
      pend_q <= pend_d;
    end
  end

  assign out_valid_o = busy_q;
  assign tx_byte_o   = msg_byte(sel_q, idx_q);
  assign tx_last_o   = out_last;

  // ---- assertions ----
  `ASSERT_PROP(a_pend_behind_busy, pend_q.valid |-> busy_q)
  `ASSERT_PROP(a_idx_in_range, busy_q |-> (idx_q < msg_len(sel_q)))
  `ASSERT_PROP(a_payload_left, (phase_q == PhPayload) |-> (left_q != 8'd0))
  `ASSERT_PROP(a_done_no_next, emit_done && !pend_q.valid && !(acc && new_desc.valid) |=> !busy_q)

endmodule
